[sv/tti_pkg.sv]
// ----------------------------------------------------------------------------
// tti_pkg: shared types, constants and a function of the text-to-integer parser
// Beat types of both channels, parse phase codes and the byte classifier.
// ----------------------------------------------------------------------------
package tti_pkg;

    localparam int RADIX_W          = 6;
    localparam int COUNT_W          = 16;
    localparam int RESULT_W         = 32;
    localparam int PHASE_W          = 3;
    localparam int VALUE_BITS_DEF   = 32;
    localparam int unsigned MAX_LENGTH_DEF = 65535;

    localparam logic [PHASE_W-1:0] PH_SPACE  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_FIRST  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ZERO   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DIGITS = 3'd3;
    localparam logic [PHASE_W-1:0] PH_SUFFIX = 3'd4;
    localparam logic [PHASE_W-1:0] PH_DONE   = 3'd5;

    localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_OCT = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;

    localparam logic [1:0] SUFFIX_L = 2'b10;
    localparam logic [1:0] SUFFIX_U = 2'b01;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_beat;

    typedef struct packed {
        logic signed [RESULT_W-1:0] value;
        logic [COUNT_W-1:0]         consumed;
        logic                       overflow;
    } t_out_beat;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               negative;
        logic [RADIX_W-1:0] base;
        logic               overflow_seen;
        logic [1:0]         suffix_seen;
    } t_parse_ctl;

    typedef struct packed {
        logic               is_blank;
        logic               is_sign;
        logic               is_minus;
        logic               is_zero;
        logic               is_x;
        logic               is_l;
        logic               is_u;
        logic               is_digit;
        logic [RADIX_W-1:0] digit;
    } t_char_class;

    function automatic t_char_class classify(input logic [7:0] c);
        t_char_class r;
        r          = '0;
        r.is_blank = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
        r.is_sign  = (c == 8'h2B) || (c == 8'h2D);
        r.is_minus = (c == 8'h2D);
        r.is_zero  = (c == 8'h30);
        r.is_x     = (c == 8'h78) || (c == 8'h58);
        r.is_l     = (c == 8'h6C) || (c == 8'h4C);
        r.is_u     = (c == 8'h75) || (c == 8'h55);
        if (c >= 8'h30 && c <= 8'h39) begin
            r.is_digit = 1'b1;
            r.digit    = RADIX_W'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r.is_digit = 1'b1;
            r.digit    = RADIX_W'(c - 8'h61 + 8'd10);
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            r.is_digit = 1'b1;
            r.digit    = RADIX_W'(c - 8'h41 + 8'd10);
        end
        return r;
    endfunction

endpackage

[sv/tti_step.sv]
// ----------------------------------------------------------------------------
// tti_step: next parse state for one text byte
// Runs the phase chain for one byte, including the radix multiply-add.
// ----------------------------------------------------------------------------
module tti_step #(
    parameter int          VALUE_BITS = tti_pkg::VALUE_BITS_DEF,
    parameter int unsigned MAX_LENGTH = tti_pkg::MAX_LENGTH_DEF
) (
    input  tti_pkg::t_parse_ctl              i_ctl,
    input  logic [VALUE_BITS-1:0]            i_acc,
    input  logic [tti_pkg::COUNT_W-1:0]      i_count,
    input  logic [7:0]                       i_ch,
    input  logic [tti_pkg::RADIX_W-1:0]      i_radix,
    output tti_pkg::t_parse_ctl              o_ctl,
    output logic [VALUE_BITS-1:0]            o_acc,
    output logic [tti_pkg::COUNT_W-1:0]      o_count
);

    localparam int PW = VALUE_BITS + tti_pkg::RADIX_W;
    localparam logic [tti_pkg::COUNT_W-1:0] COUNT_LIMIT =
        (MAX_LENGTH < 65535) ? tti_pkg::COUNT_W'(MAX_LENGTH) : 16'hFFFF;

    tti_pkg::t_char_class            cls;
    logic [tti_pkg::RADIX_W-1:0]     mul_base;
    logic [PW-1:0]                   prod;
    logic [VALUE_BITS-1:0]           sum;

    assign cls = tti_pkg::classify(i_ch);

    always_comb begin
        tti_pkg::t_parse_ctl c;
        logic go;
        logic take;
        logic add;
        c    = i_ctl;
        go   = 1'b1;
        take = 1'b0;
        add  = 1'b0;

        if (go && c.phase == tti_pkg::PH_SPACE) begin
            if (cls.is_blank) begin
                take = 1'b1;
                go   = 1'b0;
            end else if (cls.is_sign) begin
                c.negative = cls.is_minus;
                take       = 1'b1;
                c.phase    = tti_pkg::PH_FIRST;
                go         = 1'b0;
            end else begin
                c.phase = tti_pkg::PH_FIRST;
            end
        end

        if (go && c.phase == tti_pkg::PH_FIRST) begin
            if (i_radix <= 6'd1) begin
                if (!cls.is_zero) begin
                    c.base  = tti_pkg::RADIX_DEC;
                    c.phase = tti_pkg::PH_DIGITS;
                end else begin
                    c.base  = tti_pkg::RADIX_OCT;
                    take    = 1'b1;
                    c.phase = tti_pkg::PH_ZERO;
                    go      = 1'b0;
                end
            end else begin
                c.base = i_radix;
                if (i_radix == tti_pkg::RADIX_HEX && cls.is_zero) begin
                    take    = 1'b1;
                    c.phase = tti_pkg::PH_ZERO;
                    go      = 1'b0;
                end else begin
                    c.phase = tti_pkg::PH_DIGITS;
                end
            end
        end

        if (go && c.phase == tti_pkg::PH_ZERO) begin
            if (cls.is_x) begin
                c.base  = tti_pkg::RADIX_HEX;
                take    = 1'b1;
                c.phase = tti_pkg::PH_DIGITS;
                go      = 1'b0;
            end else begin
                c.phase = tti_pkg::PH_DIGITS;
            end
        end

        if (go && c.phase == tti_pkg::PH_DIGITS) begin
            if (cls.is_digit && cls.digit < c.base) begin
                add  = 1'b1;
                take = 1'b1;
                go   = 1'b0;
            end else begin
                c.phase = tti_pkg::PH_SUFFIX;
            end
        end

        if (go && c.phase == tti_pkg::PH_SUFFIX) begin
            if (cls.is_l && !c.suffix_seen[1]) begin
                c.suffix_seen = c.suffix_seen | tti_pkg::SUFFIX_L;
                take          = 1'b1;
            end else if (cls.is_u && !c.suffix_seen[0]) begin
                c.suffix_seen = c.suffix_seen | tti_pkg::SUFFIX_U;
                take          = 1'b1;
            end else begin
                c.phase = tti_pkg::PH_DONE;
            end
        end

        mul_base = (c.base != '0) ? c.base : tti_pkg::RADIX_DEC;
        prod     = PW'(i_acc) * PW'(mul_base);
        sum      = prod[VALUE_BITS-1:0] + VALUE_BITS'(cls.digit);

        o_acc = i_acc;
        if (add) begin
            o_acc = sum;
            if ((|prod[PW-1:VALUE_BITS]) || (sum < i_acc)) begin
                c.overflow_seen = 1'b1;
            end
        end

        o_count = (take && i_count < COUNT_LIMIT) ? i_count + 1'b1 : i_count;
        o_ctl   = c;
    end

endmodule

[sv/tti_result.sv]
// ----------------------------------------------------------------------------
// tti_result: result beat from the final parse state
// Applies the sign, checks the signed range and widens to the result width.
// ----------------------------------------------------------------------------
module tti_result #(
    parameter int VALUE_BITS = tti_pkg::VALUE_BITS_DEF
) (
    input  tti_pkg::t_parse_ctl          i_ctl,
    input  logic [VALUE_BITS-1:0]        i_acc,
    input  logic [tti_pkg::COUNT_W-1:0]  i_count,
    output tti_pkg::t_out_beat           o_beat
);

    logic [VALUE_BITS-1:0] res;
    logic [63:0]           ext;
    logic                  ovf;

    always_comb begin
        if (i_ctl.negative) begin
            res = VALUE_BITS'(0) - i_acc;
            ovf = i_ctl.overflow_seen || ((res != '0) && !res[VALUE_BITS-1]);
        end else begin
            res = i_acc;
            ovf = i_ctl.overflow_seen || res[VALUE_BITS-1];
        end
        ext             = 64'($signed(res));
        o_beat.value    = $signed(ext[tti_pkg::RESULT_W-1:0]);
        o_beat.consumed = i_count;
        o_beat.overflow = ovf;
    end

endmodule

[sv/text_to_integer_parser.sv]
// ----------------------------------------------------------------------------
// text_to_integer_parser: strtol-style integer parser over a byte stream
// Parses one text byte per beat and gives one result beat per buffer.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Beat
//  in       input      i_in_valid/o_in_stall    t_in_beat  (ch, last)
//  out      output     o_out_valid/i_out_stall  t_out_beat (value, consumed, overflow)
//  cfg      input      i_cfg_valid/o_cfg_ready  radix, 6 bits
//
// One byte is accepted every cycle unless a last byte waits on a stalled
// result; the result of a last byte passes the input register, then the result register.
// The parse state and result register are loaded directly from the input
// register through one radix multiply-add. Reset is synchronous and clears
// the parse state and the radix. A stalled result holds only a last byte in
// the input register; other bytes keep flowing.
module text_to_integer_parser #(
    parameter int          VALUE_BITS = tti_pkg::VALUE_BITS_DEF,
    parameter int unsigned MAX_LENGTH = tti_pkg::MAX_LENGTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  tti_pkg::t_in_beat             i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output tti_pkg::t_out_beat            o_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tti_pkg::RADIX_W-1:0]   i_cfg_data
);

    logic                          r_in_vld;
    tti_pkg::t_in_beat             r_in;
    logic                          r_out_vld;
    tti_pkg::t_out_beat            r_out;
    logic [tti_pkg::RADIX_W-1:0]   r_radix;
    tti_pkg::t_parse_ctl           r_ctl;
    logic [VALUE_BITS-1:0]         r_acc;
    logic [tti_pkg::COUNT_W-1:0]   r_count;

    tti_pkg::t_parse_ctl           n_ctl;
    logic [VALUE_BITS-1:0]         n_acc;
    logic [tti_pkg::COUNT_W-1:0]   n_count;
    tti_pkg::t_out_beat            n_out;

    logic adv;
    logic in_acc;

    tti_step #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_LENGTH (MAX_LENGTH)
    ) u_step (
        .i_ctl   (r_ctl),
        .i_acc   (r_acc),
        .i_count (r_count),
        .i_ch    (r_in.ch),
        .i_radix (r_radix),
        .o_ctl   (n_ctl),
        .o_acc   (n_acc),
        .o_count (n_count)
    );

    tti_result #(
        .VALUE_BITS (VALUE_BITS)
    ) u_result (
        .i_ctl   (n_ctl),
        .i_acc   (n_acc),
        .i_count (n_count),
        .o_beat  (n_out)
    );

    assign adv         = r_in_vld && (!r_in.last || !r_out_vld || !i_out_stall);
    assign o_in_stall  = r_in_vld && !adv;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_radix   <= '0;
            r_ctl     <= '0;
            r_acc     <= '0;
            r_count   <= '0;
        end else begin
            if (in_acc) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end

            if (i_cfg_valid && o_cfg_ready) begin
                r_radix <= i_cfg_data;
            end

            if (adv && r_in.last) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end

            if (adv) begin
                if (r_in.last) begin
                    r_ctl   <= '0;
                    r_acc   <= '0;
                    r_count <= '0;
                end else begin
                    r_ctl   <= n_ctl;
                    r_acc   <= n_acc;
                    r_count <= n_count;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in;
        end
        if (adv && r_in.last) begin
            r_out <= n_out;
        end
    end

endmodule

[test/tti_result_checker.sv]
// ----------------------------------------------------------------------------
// tti_result_checker: result predictor and comparator for the integer parser
// Watches the byte, result and radix channels of the parser. Each accepted
// byte is parsed by an independent model of the parse state, and each byte
// marked last queues the expected result. Accepted result beats are compared
// field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module tti_result_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  tti_pkg::t_in_beat           i_in,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  tti_pkg::t_out_beat          i_out,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [tti_pkg::RADIX_W-1:0] i_cfg_data,
    output int                          o_mismatches,
    output int                          o_pending
);

    import tti_pkg::*;

    localparam int NO_DIGIT = 99;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_UP_X   = 8'h58;
    localparam logic [7:0] CH_LOW_L  = 8'h6C;
    localparam logic [7:0] CH_UP_L   = 8'h4C;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_UP_U   = 8'h55;

    logic [RADIX_W-1:0]  radix_reg;
    logic [PHASE_W-1:0]  phase;
    logic                negative;
    logic [RADIX_W-1:0]  base;
    logic [RESULT_W-1:0] accum;
    logic                accum_overflow;
    logic [COUNT_W-1:0]  byte_count;
    logic [1:0]          suffixes;
    t_out_beat           expected_results[$];

    function automatic int char_digit(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
        if (c >= CH_LOW_A && c <= CH_LOW_Z) return int'(c - CH_LOW_A) + 10;
        if (c >= CH_UP_A && c <= CH_UP_Z) return int'(c - CH_UP_A) + 10;
        return NO_DIGIT;
    endfunction

    function automatic void count_byte();
        if (byte_count != {COUNT_W{1'b1}}) byte_count = byte_count + 1'b1;
    endfunction

    function automatic void accumulate(input int d);
        logic [RESULT_W-1:0] prev;
        logic [63:0]         wide;
        int unsigned         b;
        b    = (base != '0) ? base : RADIX_DEC;
        prev = accum;
        if ({RESULT_W{1'b1}} / b < accum) accum_overflow = 1'b1;
        wide  = 64'(accum) * 64'(b) + 64'(d);
        accum = wide[RESULT_W-1:0];
        if (accum < prev) accum_overflow = 1'b1;
    endfunction

    function automatic void clear_parse();
        phase          = PH_SPACE;
        negative       = 1'b0;
        base           = '0;
        accum          = '0;
        accum_overflow = 1'b0;
        byte_count     = '0;
        suffixes       = '0;
    endfunction

    function automatic void parse_text_byte(input logic [7:0] c);
        bit again;
        int d;
        again = 1'b1;
        while (again) begin
            again = 1'b0;
            case (phase)
                PH_SPACE: begin
                    if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                        count_byte();
                    end else if (c == CH_PLUS || c == CH_MINUS) begin
                        negative = (c == CH_MINUS);
                        count_byte();
                        phase = PH_FIRST;
                    end else begin
                        phase = PH_FIRST;
                        again = 1'b1;
                    end
                end
                PH_FIRST: begin
                    if (radix_reg <= 6'd1) begin
                        if (c != CH_ZERO) begin
                            base  = RADIX_DEC;
                            phase = PH_DIGITS;
                            again = 1'b1;
                        end else begin
                            base = RADIX_OCT;
                            count_byte();
                            phase = PH_ZERO;
                        end
                    end else begin
                        base = radix_reg;
                        if (radix_reg == RADIX_HEX && c == CH_ZERO) begin
                            count_byte();
                            phase = PH_ZERO;
                        end else begin
                            phase = PH_DIGITS;
                            again = 1'b1;
                        end
                    end
                end
                PH_ZERO: begin
                    if (c == CH_LOW_X || c == CH_UP_X) begin
                        base = RADIX_HEX;
                        count_byte();
                        phase = PH_DIGITS;
                    end else begin
                        phase = PH_DIGITS;
                        again = 1'b1;
                    end
                end
                PH_DIGITS: begin
                    d = char_digit(c);
                    if (d < int'(base)) begin
                        accumulate(d);
                        count_byte();
                    end else begin
                        phase = PH_SUFFIX;
                        again = 1'b1;
                    end
                end
                PH_SUFFIX: begin
                    if ((c == CH_LOW_L || c == CH_UP_L) && (suffixes & SUFFIX_L) == '0) begin
                        suffixes = suffixes | SUFFIX_L;
                        count_byte();
                    end else if ((c == CH_LOW_U || c == CH_UP_U) &&
                                 (suffixes & SUFFIX_U) == '0) begin
                        suffixes = suffixes | SUFFIX_U;
                        count_byte();
                    end else begin
                        phase = PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end
    endfunction

    function automatic t_out_beat close_buffer();
        t_out_beat           beat;
        logic [RESULT_W-1:0] res;
        logic                ovf;
        ovf = accum_overflow;
        if (negative) begin
            res = '0 - accum;
            if (res != '0 && !res[RESULT_W-1]) ovf = 1'b1;
        end else begin
            res = accum;
            if (res[RESULT_W-1]) ovf = 1'b1;
        end
        beat.value    = res;
        beat.consumed = byte_count;
        beat.overflow = ovf;
        clear_parse();
        return beat;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] result mismatch: %s", $realtime, what);
        o_mismatches = o_mismatches + 1;
    endtask

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            radix_reg = '0;
            clear_parse();
            expected_results.delete();
            o_mismatches = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat value %0d consumed %0d",
                                              i_out.value, i_out.consumed));
                end else begin
                    want = expected_results.pop_front();
                    if (i_out.value !== want.value)
                        report_mismatch($sformatf("value %0d, expected %0d",
                                                  i_out.value, want.value));
                    if (i_out.consumed !== want.consumed)
                        report_mismatch($sformatf("consumed %0d, expected %0d",
                                                  i_out.consumed, want.consumed));
                    if (i_out.overflow !== want.overflow)
                        report_mismatch($sformatf("overflow %b, expected %b",
                                                  i_out.overflow, want.overflow));
                end
            end
            if (i_cfg_valid && i_cfg_ready) radix_reg = i_cfg_data;
            if (i_in_valid && !i_in_stall) begin
                parse_text_byte(i_in.ch);
                if (i_in.last) expected_results.push_back(close_buffer());
            end
        end
        o_pending = expected_results.size();
    end

endmodule

[test/tb_text_to_integer_parser.sv]
// ----------------------------------------------------------------------------
// tb_text_to_integer_parser: testbench of the text-to-integer parser
// Sends directed text buffers covering signs, prefixes, suffixes, overflow
// and radix settings, then random buffers under several radix settings,
// with random idling on both channels. A separate checker predicts every
// result and compares it with the parser's output.
// ----------------------------------------------------------------------------
module tb_text_to_integer_parser;

    import tti_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int HOLD_CYCLES    = 80;
    localparam int SETTLE_CYCLES  = 6;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_BYTES    = 60;

    localparam logic [RADIX_W-1:0] RADIX_AUTO     = 6'd0;
    localparam logic [RADIX_W-1:0] RADIX_AUTO_ALT = 6'd1;
    localparam logic [RADIX_W-1:0] RADIX_BIN      = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_ALNUM    = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_WIDE     = 6'd37;
    localparam logic [RADIX_W-1:0] RADIX_MAX      = 6'd63;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    t_in_beat           in_beat = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    t_out_beat          out_beat;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [RADIX_W-1:0] cfg_data = '0;

    int                 mismatch_count;
    int                 results_pending;
    int                 cycle_count = 0;
    bit                 idle_on = 1'b1;
    bit                 quiet = 1'b0;
    bit                 hold_request = 1'b0;
    logic [RADIX_W-1:0] cur_radix = RADIX_AUTO;
    logic [7:0]         text_bytes[$];
    logic [7:0]         blank_set[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    logic [RADIX_W-1:0] phase_radix[RANDOM_PHASES] = '{RADIX_AUTO, RADIX_DEC, RADIX_HEX,
        RADIX_AUTO_ALT, RADIX_OCT, RADIX_BIN, RADIX_ALNUM, RADIX_MAX, RADIX_WIDE, RADIX_AUTO};

    text_to_integer_parser dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    tti_result_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_beat),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_beat),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatch_count),
        .o_pending    (results_pending)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // The result side stalls in random bursts, or for one long stretch on request.
    always begin
        @(negedge clk);
        if (hold_request) begin
            hold_request = 1'b0;
            out_stall    = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            out_stall = 1'b0;
        end else if (idle_on && !quiet && $urandom_range(0, 5) == 0) begin
            out_stall = 1'b1;
            repeat ($urandom_range(1, 10)) @(negedge clk);
            out_stall = 1'b0;
        end
    end

    task automatic send_byte(input logic [7:0] ch, input logic last);
        if (idle_on && !quiet && $urandom_range(0, 5) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        in_valid     = 1'b1;
        in_beat.ch   = ch;
        in_beat.last = last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    endtask

    task automatic send_text_bytes();
        foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1);
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        wait (results_pending == 0);
        @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_radix(input logic [RADIX_W-1:0] r);
        in_valid  = 1'b0;
        cfg_valid = 1'b1;
        cfg_data  = r;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        cur_radix = r;
    endtask

    task automatic build_random_text();
        int kind;
        int b;
        int v;
        int n;
        bit auto_plain;
        text_bytes.delete();
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 6)) text_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, 2)) text_bytes.push_back(blank_set[$urandom_range(0, 5)]);
            case ($urandom_range(0, 3))
                0: text_bytes.push_back("+");
                1: text_bytes.push_back("-");
                default: begin
                end
            endcase
            b          = (cur_radix <= RADIX_AUTO_ALT) ? RADIX_DEC : cur_radix;
            auto_plain = 1'b0;
            if (cur_radix <= RADIX_AUTO_ALT) begin
                case ($urandom_range(0, 3))
                    0: begin
                        text_bytes.push_back("0");
                        text_bytes.push_back($urandom_range(0, 1) ? "x" : "X");
                        b = RADIX_HEX;
                    end
                    1: begin
                        text_bytes.push_back("0");
                        b = RADIX_OCT;
                    end
                    default: auto_plain = 1'b1;
                endcase
            end else if (cur_radix == RADIX_HEX && $urandom_range(0, 2) == 0) begin
                text_bytes.push_back("0");
                text_bytes.push_back($urandom_range(0, 1) ? "x" : "X");
            end
            n = (kind == 1) ? 0 : $urandom_range(1, 12);
            for (int i = 0; i < n; i++) begin
                if (b > 36) v = $urandom_range(0, 35);
                else if (auto_plain && i == 0) v = $urandom_range(1, b - 1);
                else if ($urandom_range(0, 3) == 0) v = b - 1;
                else v = $urandom_range(0, b - 1);
                if (v < 10) text_bytes.push_back(8'h30 + 8'(v));
                else text_bytes.push_back(($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v - 10));
            end
            repeat ($urandom_range(0, 2)) begin
                case ($urandom_range(0, 3))
                    0: text_bytes.push_back("l");
                    1: text_bytes.push_back("L");
                    2: text_bytes.push_back("u");
                    default: text_bytes.push_back("U");
                endcase
            end
            if (kind == 2)
                repeat ($urandom_range(1, 3)) text_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int  sent;
        bit  paused;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        send_text("  +123");
        send_text("\011\012\013\014\015-456");
        send_text("-2147483648");
        send_text("2147483648");
        send_text("4294967296");
        send_text("-0x7fffffff");
        send_text("0XABCDEFlu");
        send_text("0777uL");
        send_text("0x");
        send_text("08");
        send_text("0");
        send_text("-");
        send_text(" ");
        send_text("12lulx");
        send_text("\377zz");
        send_byte(8'h00, 1'b1);

        wait_drained();
        write_radix(RADIX_HEX);
        send_text("0x1F");
        send_text("-1f");
        send_text("0");
        wait_drained();
        write_radix(RADIX_ALNUM);
        send_text("Zz");
        wait_drained();
        write_radix(RADIX_MAX);
        send_text("zZ9");
        wait_drained();
        write_radix(RADIX_BIN);
        send_text("-1012");
        wait_drained();
        write_radix(RADIX_OCT);
        send_text("0x7");
        wait_drained();
        write_radix(RADIX_AUTO_ALT);
        send_text("0x10");

        // A radix change in mid-buffer only applies from the next buffer.
        send_byte(" ", 1'b0);
        send_byte("-", 1'b0);
        send_byte("1", 1'b0);
        wait_drained();
        write_radix(RADIX_BIN);
        send_text("79");
        send_text("101");

        paused = 1'b0;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_drained();
            if (p == RANDOM_PHASES - 1) write_radix(6'($urandom_range(0, 63)));
            else write_radix(phase_radix[p]);
            quiet = (p == RANDOM_PHASES - 1);
            if (p == 2) begin
                idle_on      = 1'b0;
                hold_request = 1'b1;
            end
            sent = 0;
            while (sent < PHASE_BYTES) begin
                if (p != 2) idle_on = ($urandom_range(0, 3) != 0);
                if (p == 4 && !paused && sent > PHASE_BYTES / 2) begin
                    paused = 1'b1;
                    wait_drained();
                end
                build_random_text();
                send_text_bytes();
                sent += text_bytes.size();
            end
        end

        wait_drained();
        if (mismatch_count == 0 && results_pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
